/* rtl/core/sdc_pkg.sv */
// Shared widths, calendar constants and pipeline control types of the serial date converter.
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

  // Fraction of a day: binary point after FRACTION_BITS bits
  localparam int unsigned FRACTION_BITS = 32;
  localparam int unsigned FRAC_IN_W     = 32;

  // Field widths
  localparam int unsigned DAY_W   = 22;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned YDAY_W  = 9;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // Register stages from request to response
  localparam int unsigned NUM_STAGES = 9;

  // Largest fraction that still rounds down to zero seconds
  localparam longint unsigned FRAC_MASK    = (64'd1 << FRACTION_BITS) - 64'd1;
  localparam longint unsigned SUBSEC_LIMIT = FRAC_MASK / 64'd86400;

  // Days from 0000-03-01 to 1899-12-30, and the weekday of 1899-12-30
  localparam int unsigned EPOCH_SHIFT   = 693899;
  localparam int unsigned EPOCH_WEEKDAY = 6;

  // Shifted day count and its split into 400-year eras
  localparam int unsigned Z_W           = 23;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned ERA_W         = 6;
  localparam int unsigned ERA_SHIFT     = Z_W + $clog2(DAYS_PER_ERA);
  localparam int unsigned ERA_MUL_W     = Z_W + 1;
  localparam longint unsigned ERA_MUL   =
    ((64'd1 << ERA_SHIFT) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA);

  // Weekday: quotient by seven through a reciprocal
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned WQ_W          = 20;
  localparam int unsigned WEEK_SHIFT    = Z_W + $clog2(DAYS_PER_WEEK);
  localparam int unsigned WEEK_MUL_W    = Z_W + 1;
  localparam longint unsigned WEEK_MUL  =
    ((64'd1 << WEEK_SHIFT) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK);

  // Day of era and its leap corrections
  localparam int unsigned DOE_W          = 18;
  localparam int unsigned DAYS_PER_4Y    = 1460;
  localparam int unsigned DAYS_PER_100Y  = 36524;
  localparam int unsigned LAST_ERA_DAY   = 146096;
  localparam int unsigned Q4Y_W          = 7;
  localparam int unsigned Q100Y_W        = 3;
  localparam int unsigned D4Y_SHIFT      = DOE_W + $clog2(DAYS_PER_4Y);
  localparam int unsigned D4Y_MUL_W      = DOE_W + 1;
  localparam longint unsigned D4Y_MUL    =
    ((64'd1 << D4Y_SHIFT) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y);

  // Year of era
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned YOE_W          = 9;
  localparam int unsigned YEARS_PER_ERA  = 400;
  localparam int unsigned YEARS_PER_CENT = 100;
  localparam int unsigned YR_SHIFT       = DOE_W + $clog2(DAYS_PER_YEAR);
  localparam int unsigned YR_MUL_W       = DOE_W + 1;
  localparam longint unsigned YR_MUL     =
    ((64'd1 << YR_SHIFT) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR);

  // Day of year from March 1 and month from March
  localparam int unsigned DOY_W         = 9;
  localparam int unsigned MP_W          = 4;
  localparam int unsigned MP_ARG_W      = 11;
  localparam int unsigned DAYS_PER_5MON = 153;
  localparam int unsigned MP_SHIFT      = MP_ARG_W + $clog2(DAYS_PER_5MON);
  localparam int unsigned MP_MUL_W      = MP_ARG_W + 1;
  localparam longint unsigned MP_MUL    =
    ((64'd1 << MP_SHIFT) + 64'(DAYS_PER_5MON) - 64'd1) / 64'(DAYS_PER_5MON);
  localparam int unsigned MP_JANUARY    = 10;
  localparam int unsigned DAYS_MAR_DEC  = 306;
  localparam int unsigned DAYS_JAN_FEB  = 59;

  // Calendar year before era scaling, and the year offset base
  localparam int unsigned YBASE_W    = YEAR_W;
  localparam int unsigned YEAR_ORIGIN = 1900;

  // Per-stage load enables handed from the flow control to the datapaths
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/sdc_in_if.sv */
// Request channel of the serial date converter: day count and day fraction.
`timescale 1ns / 1ps
`default_nettype none

interface sdc_in_if;
  import sdc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DAY_W-1:0]     day_count;
  logic [FRAC_IN_W-1:0] day_fraction;

  modport source (output valid, output day_count, output day_fraction, input ready);
  modport sink   (input valid, input day_count, input day_fraction, output ready);

endinterface

`default_nettype wire

/* rtl/core/sdc_out_if.sv */
// Response channel of the serial date converter: calendar and clock fields.
`timescale 1ns / 1ps
`default_nettype none

interface sdc_out_if;
  import sdc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year_offset;
  logic [MONTH_W-1:0]       month_index;
  logic [MDAY_W-1:0]        day_of_month;
  logic [WDAY_W-1:0]        week_day;
  logic [YDAY_W-1:0]        year_day;
  logic [HOUR_W-1:0]        hour_value;
  logic [MIN_W-1:0]         minute_value;
  logic [SEC_W-1:0]         second_value;

  modport source (
    output valid, output year_offset, output month_index, output day_of_month,
    output week_day, output year_day, output hour_value, output minute_value,
    output second_value, input ready
  );
  modport sink (
    input valid, input year_offset, input month_index, input day_of_month,
    input week_day, input year_day, input hour_value, input minute_value,
    input second_value, output ready
  );

endinterface

`default_nettype wire

/* rtl/core/sdc_date_path.sv */
// Calendar datapath: day count to year, month, day, weekday and day of year.
`timescale 1ns / 1ps
`default_nettype none

module sdc_date_path (
  input  logic                         clk_i,
  input  sdc_pkg::stage_ctrl_t         ctrl_i,
  input  logic [sdc_pkg::DAY_W-1:0]    day_count_i,
  output logic [sdc_pkg::YEAR_W-1:0]   year_offset_o,
  output logic [sdc_pkg::MONTH_W-1:0]  month_index_o,
  output logic [sdc_pkg::MDAY_W-1:0]   day_of_month_o,
  output logic [sdc_pkg::WDAY_W-1:0]   week_day_o,
  output logic [sdc_pkg::YDAY_W-1:0]   year_day_o
);
  import sdc_pkg::*;

  // First day of each month counted from March 1
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] r;
    case (mp)
      4'd0:    r = DOY_W'(0);
      4'd1:    r = DOY_W'(31);
      4'd2:    r = DOY_W'(61);
      4'd3:    r = DOY_W'(92);
      4'd4:    r = DOY_W'(122);
      4'd5:    r = DOY_W'(153);
      4'd6:    r = DOY_W'(184);
      4'd7:    r = DOY_W'(214);
      4'd8:    r = DOY_W'(245);
      4'd9:    r = DOY_W'(275);
      4'd10:   r = DOY_W'(306);
      4'd11:   r = DOY_W'(337);
      default: r = DOY_W'(0);
    endcase
    return r;
  endfunction

  // Stage 1
  logic [Z_W-1:0] z1_d, z1_q, w1_d, w1_q;
  // Stage 2
  logic [Z_W+ERA_MUL_W-1:0]  era_prod;
  logic [Z_W+WEEK_MUL_W-1:0] week_prod;
  logic [ERA_W-1:0]          era2_d, era2_q;
  logic [WQ_W-1:0]           wq2_d, wq2_q;
  logic [Z_W-1:0]            z2_q, w2_q;
  // Stage 3
  logic [Z_W-1:0]    era_days, week_days, week_rem;
  logic [DOE_W-1:0]  doe3_d, doe3_q;
  logic [WDAY_W-1:0] wday3_d, wday3_q;
  logic [ERA_W-1:0]  era3_q;
  // Stage 4
  logic [DOE_W+D4Y_MUL_W-1:0] d4y_prod;
  logic [Q4Y_W-1:0]           q4y4_d, q4y4_q;
  logic [Q100Y_W-1:0]         q100y4_d, q100y4_q;
  logic                       qera4_d, qera4_q;
  logic [DOE_W-1:0]           doe4_q;
  logic [ERA_W-1:0]           era4_q;
  logic [WDAY_W-1:0]          wday4_q;
  // Stage 5
  logic [DOE_W-1:0]  n5_d, n5_q, doe5_q;
  logic [ERA_W-1:0]  era5_q;
  logic [WDAY_W-1:0] wday5_q;
  // Stage 6
  logic [DOE_W+YR_MUL_W-1:0] yr_prod;
  logic [YOE_W-1:0]          yoe6_d, yoe6_q;
  logic [DOE_W-1:0]          doe6_q;
  logic [ERA_W-1:0]          era6_q;
  logic [WDAY_W-1:0]         wday6_q;
  // Stage 7
  logic [DOE_W-1:0]   yoe_days;
  logic [1:0]         cent7;
  logic [DOY_W-1:0]   doy7_d, doy7_q;
  logic [YBASE_W-1:0] ybase7_d, ybase7_q;
  logic               leap7_d, leap7_q;
  logic [WDAY_W-1:0]  wday7_q;
  // Stage 8
  logic [MP_ARG_W-1:0]          mp_arg;
  logic [MP_ARG_W+MP_MUL_W-1:0] mp_prod;
  logic [MP_W-1:0]              mp8_d, mp8_q;
  logic [DOY_W-1:0]             doy8_q;
  logic [YBASE_W-1:0]           ybase8_q;
  logic                         leap8_q;
  logic [WDAY_W-1:0]            wday8_q;
  // Stage 9
  logic                  late9;
  logic [YEAR_W-1:0]     year9_d, year9_q;
  logic [MONTH_W-1:0]    month9_d, month9_q;
  logic [MDAY_W-1:0]     mday9_d, mday9_q;
  logic [YDAY_W-1:0]     yday9_d, yday9_q;
  logic [WDAY_W-1:0]     wday9_q;

  // Shift the count to a March-based epoch and bias the weekday
  always_comb begin
    z1_d = Z_W'(day_count_i) + Z_W'(EPOCH_SHIFT);
    w1_d = Z_W'(day_count_i) + Z_W'(EPOCH_WEEKDAY);
  end

  // Era and week quotients by reciprocal multiplication
  always_comb begin
    era_prod  = {{ERA_MUL_W{1'b0}}, z1_q} * {{Z_W{1'b0}}, ERA_MUL[ERA_MUL_W-1:0]};
    week_prod = {{WEEK_MUL_W{1'b0}}, w1_q} * {{Z_W{1'b0}}, WEEK_MUL[WEEK_MUL_W-1:0]};
    era2_d    = era_prod[ERA_SHIFT +: ERA_W];
    wq2_d     = week_prod[WEEK_SHIFT +: WQ_W];
  end

  // Remainders: day of era and weekday
  always_comb begin
    era_days  = Z_W'(era2_q) * Z_W'(DAYS_PER_ERA);
    week_days = Z_W'(wq2_q) * Z_W'(DAYS_PER_WEEK);
    week_rem  = w2_q - week_days;
    doe3_d    = DOE_W'(z2_q - era_days);
    wday3_d   = week_rem[WDAY_W-1:0];
  end

  // Leap corrections within the era
  always_comb begin
    d4y_prod = {{D4Y_MUL_W{1'b0}}, doe3_q} * {{DOE_W{1'b0}}, D4Y_MUL[D4Y_MUL_W-1:0]};
    q4y4_d   = d4y_prod[D4Y_SHIFT +: Q4Y_W];
    q100y4_d = Q100Y_W'(doe3_q >= DOE_W'(DAYS_PER_100Y))
             + Q100Y_W'(doe3_q >= DOE_W'(2 * DAYS_PER_100Y))
             + Q100Y_W'(doe3_q >= DOE_W'(3 * DAYS_PER_100Y))
             + Q100Y_W'(doe3_q >= DOE_W'(LAST_ERA_DAY));
    qera4_d  = (doe3_q == DOE_W'(LAST_ERA_DAY));
  end

  // Day count as if every year had 365 days
  always_comb begin
    n5_d = DOE_W'(doe4_q - DOE_W'(q4y4_q) + DOE_W'(q100y4_q) - DOE_W'(qera4_q));
  end

  // Year of era
  always_comb begin
    yr_prod = {{YR_MUL_W{1'b0}}, n5_q} * {{DOE_W{1'b0}}, YR_MUL[YR_MUL_W-1:0]};
    yoe6_d  = yr_prod[YR_SHIFT +: YOE_W];
  end

  // Day of year from March 1, year base and leap flag of the March-based year
  always_comb begin
    cent7    = 2'(yoe6_q >= YOE_W'(YEARS_PER_CENT))
             + 2'(yoe6_q >= YOE_W'(2 * YEARS_PER_CENT))
             + 2'(yoe6_q >= YOE_W'(3 * YEARS_PER_CENT));
    yoe_days = DOE_W'(yoe6_q) * DOE_W'(DAYS_PER_YEAR)
             + DOE_W'(yoe6_q >> 2) - DOE_W'(cent7);
    doy7_d   = DOY_W'(doe6_q - yoe_days);
    ybase7_d = YBASE_W'(yoe6_q) + YBASE_W'(era6_q) * YBASE_W'(YEARS_PER_ERA);
    leap7_d  = (yoe6_q[1:0] == 2'b00) && (yoe6_q != YOE_W'(YEARS_PER_CENT))
            && (yoe6_q != YOE_W'(2 * YEARS_PER_CENT))
            && (yoe6_q != YOE_W'(3 * YEARS_PER_CENT));
  end

  // Month counted from March
  always_comb begin
    mp_arg  = MP_ARG_W'(doy7_q) * MP_ARG_W'(5) + MP_ARG_W'(2);
    mp_prod = {{MP_MUL_W{1'b0}}, mp_arg} * {{MP_ARG_W{1'b0}}, MP_MUL[MP_MUL_W-1:0]};
    mp8_d   = mp_prod[MP_SHIFT +: MP_W];
  end

  // Final calendar fields; January and February belong to the next year
  always_comb begin
    late9    = (mp8_q >= MP_W'(MP_JANUARY));
    month9_d = late9 ? MONTH_W'(mp8_q - MP_W'(MP_JANUARY)) : MONTH_W'(mp8_q + MP_W'(2));
    mday9_d  = MDAY_W'(DOY_W'(doy8_q - month_start(mp8_q)) + DOY_W'(1));
    yday9_d  = late9 ? YDAY_W'(doy8_q - DOY_W'(DAYS_MAR_DEC))
                     : YDAY_W'(doy8_q + DOY_W'(DAYS_JAN_FEB) + DOY_W'(leap8_q));
    year9_d  = YEAR_W'(ybase8_q + YBASE_W'(late9) - YBASE_W'(YEAR_ORIGIN));
  end

  // Advance each stage when its load enable is set
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      z1_q <= z1_d;
      w1_q <= w1_d;
    end
    if (ctrl_i.load[1]) begin
      era2_q <= era2_d;
      wq2_q  <= wq2_d;
      z2_q   <= z1_q;
      w2_q   <= w1_q;
    end
    if (ctrl_i.load[2]) begin
      doe3_q  <= doe3_d;
      wday3_q <= wday3_d;
      era3_q  <= era2_q;
    end
    if (ctrl_i.load[3]) begin
      q4y4_q   <= q4y4_d;
      q100y4_q <= q100y4_d;
      qera4_q  <= qera4_d;
      doe4_q   <= doe3_q;
      era4_q   <= era3_q;
      wday4_q  <= wday3_q;
    end
    if (ctrl_i.load[4]) begin
      n5_q    <= n5_d;
      doe5_q  <= doe4_q;
      era5_q  <= era4_q;
      wday5_q <= wday4_q;
    end
    if (ctrl_i.load[5]) begin
      yoe6_q  <= yoe6_d;
      doe6_q  <= doe5_q;
      era6_q  <= era5_q;
      wday6_q <= wday5_q;
    end
    if (ctrl_i.load[6]) begin
      doy7_q   <= doy7_d;
      ybase7_q <= ybase7_d;
      leap7_q  <= leap7_d;
      wday7_q  <= wday6_q;
    end
    if (ctrl_i.load[7]) begin
      mp8_q    <= mp8_d;
      doy8_q   <= doy7_q;
      ybase8_q <= ybase7_q;
      leap8_q  <= leap7_q;
      wday8_q  <= wday7_q;
    end
    if (ctrl_i.load[8]) begin
      year9_q  <= year9_d;
      month9_q <= month9_d;
      mday9_q  <= mday9_d;
      yday9_q  <= yday9_d;
      wday9_q  <= wday8_q;
    end
  end

  assign year_offset_o  = year9_q;
  assign month_index_o  = month9_q;
  assign day_of_month_o = mday9_q;
  assign week_day_o     = wday9_q;
  assign year_day_o     = yday9_q;

endmodule

`default_nettype wire

/* rtl/core/sdc_time_path.sv */
// Clock datapath: day fraction to hour, minute and second, plus the sub-second flag.
`timescale 1ns / 1ps
`default_nettype none

module sdc_time_path (
  input  logic                          clk_i,
  input  sdc_pkg::stage_ctrl_t          ctrl_i,
  input  logic [sdc_pkg::DAY_W-1:0]     day_count_i,
  input  logic [sdc_pkg::FRAC_IN_W-1:0] day_fraction_i,
  output logic                          empty_o,
  output logic [sdc_pkg::HOUR_W-1:0]    hour_value_o,
  output logic [sdc_pkg::MIN_W-1:0]     minute_value_o,
  output logic [sdc_pkg::SEC_W-1:0]     second_value_o
);
  import sdc_pkg::*;

  typedef struct packed {
    logic              empty;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } clock_fields_t;

  logic [FRACTION_BITS+FRAC_IN_W-1:0] frac_wide;
  logic [FRACTION_BITS-1:0]           frac0;
  logic [FRACTION_BITS+HOUR_W-1:0]    hour_ext, hour_prod;
  logic [FRACTION_BITS+MIN_W-1:0]     min_ext, min_prod;
  logic [FRACTION_BITS+SEC_W-1:0]     sec_ext, sec_prod;

  logic                     empty1_d, empty1_q, empty2_q;
  logic [HOUR_W-1:0]        hour1_q, hour2_q;
  logic [FRACTION_BITS-1:0] frac1_q, frac2_q;
  logic [MIN_W-1:0]         min2_q;
  clock_fields_t            fields3_d;
  clock_fields_t            fields_q [3:NUM_STAGES];

  // Keep the fraction bits below the binary point
  always_comb begin
    frac_wide = {{FRACTION_BITS{1'b0}}, day_fraction_i};
    frac0     = frac_wide[FRACTION_BITS-1:0];
    empty1_d  = (day_count_i == '0) && (frac0 <= SUBSEC_LIMIT[FRACTION_BITS-1:0]);
  end

  // Scale by 24, 60 and 60; the integer part is the field, the rest carries on
  always_comb begin
    hour_ext  = {{HOUR_W{1'b0}}, frac0};
    hour_prod = (hour_ext << 4) + (hour_ext << 3);
    min_ext   = {{MIN_W{1'b0}}, frac1_q};
    min_prod  = (min_ext << 6) - (min_ext << 2);
    sec_ext   = {{SEC_W{1'b0}}, frac2_q};
    sec_prod  = (sec_ext << 6) - (sec_ext << 2);
    fields3_d = '{empty: empty2_q, hour: hour2_q, minute: min2_q,
                  second: sec_prod[FRACTION_BITS +: SEC_W]};
  end

  // Advance the steps, then delay the fields to line up with the calendar
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      empty1_q <= empty1_d;
      hour1_q  <= hour_prod[FRACTION_BITS +: HOUR_W];
      frac1_q  <= hour_prod[FRACTION_BITS-1:0];
    end
    if (ctrl_i.load[1]) begin
      empty2_q <= empty1_q;
      hour2_q  <= hour1_q;
      min2_q   <= min_prod[FRACTION_BITS +: MIN_W];
      frac2_q  <= min_prod[FRACTION_BITS-1:0];
    end
    if (ctrl_i.load[2]) begin
      fields_q[3] <= fields3_d;
    end
    for (int k = 4; k <= NUM_STAGES; k++) begin
      if (ctrl_i.load[k-1]) begin
        fields_q[k] <= fields_q[k-1];
      end
    end
  end

  assign empty_o        = fields_q[NUM_STAGES].empty;
  assign hour_value_o   = fields_q[NUM_STAGES].hour;
  assign minute_value_o = fields_q[NUM_STAGES].minute;
  assign second_value_o = fields_q[NUM_STAGES].second;

endmodule

`default_nettype wire

/* rtl/core/serial_date_to_calendar_unit.sv */
// Top level of the serial date converter: flow control and output selection.
//
// Usage: each request on req_i carries day_count (whole days since 1899-12-30)
// and day_fraction (fraction of a day scaled by 2^32). Each request gives one
// response on rsp_o with the proleptic Gregorian year minus 1900, month 0-11,
// day of month, weekday (Sunday 0), day of year, and hour, minute and second
// truncated from the fraction. A value below one second on day zero gives an
// all-zero response.
// Pipeline: a request passes through nine register stages before its response
// is valid on rsp_o; the calendar math is cut so that each stage is about one
// short multiply or add deep.
// Throughput: one request per cycle, sustained, as long as rsp_o is taken.
// Stall: when rsp_o is not ready, the last stage holds and earlier stages keep
// filling until each holds a request; nothing is dropped or repeated. Empty
// stages are collapsed, so req_i stays ready while any stage is free.
// Reset: rst_ni clears all stage valid bits; the block takes a request in the
// first cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module serial_date_to_calendar_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdc_in_if.sink     req_i,
  sdc_out_if.source  rsp_o
);
  import sdc_pkg::*;

  logic [NUM_STAGES-1:0] v_d, v_q;
  stage_ctrl_t           ctrl;

  logic [YEAR_W-1:0]  year_offset;
  logic [MONTH_W-1:0] month_index;
  logic [MDAY_W-1:0]  day_of_month;
  logic [WDAY_W-1:0]  week_day;
  logic [YDAY_W-1:0]  year_day;
  logic               empty;
  logic [HOUR_W-1:0]  hour_value;
  logic [MIN_W-1:0]   minute_value;
  logic [SEC_W-1:0]   second_value;

  // Load a stage when it is empty or its content moves on
  always_comb begin
    ctrl.load[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || rsp_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ctrl.load[k] = !v_q[k] || ctrl.load[k+1];
    end
    v_d[0] = ctrl.load[0] ? req_i.valid : v_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_d[k] = ctrl.load[k] ? v_q[k-1] : v_q[k];
    end
  end

  // Hold the valid bits of all stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  sdc_date_path u_date (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .day_count_i    (req_i.day_count),
    .year_offset_o  (year_offset),
    .month_index_o  (month_index),
    .day_of_month_o (day_of_month),
    .week_day_o     (week_day),
    .year_day_o     (year_day)
  );

  sdc_time_path u_time (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .day_count_i    (req_i.day_count),
    .day_fraction_i (req_i.day_fraction),
    .empty_o        (empty),
    .hour_value_o   (hour_value),
    .minute_value_o (minute_value),
    .second_value_o (second_value)
  );

  assign req_i.ready = ctrl.load[0];

  // Drive the response; the sub-second value reads as all zero
  assign rsp_o.valid        = v_q[NUM_STAGES-1];
  assign rsp_o.year_offset  = empty ? '0 : $signed(year_offset);
  assign rsp_o.month_index  = empty ? '0 : month_index;
  assign rsp_o.day_of_month = empty ? '0 : day_of_month;
  assign rsp_o.week_day     = empty ? '0 : week_day;
  assign rsp_o.year_day     = empty ? '0 : year_day;
  assign rsp_o.hour_value   = empty ? '0 : hour_value;
  assign rsp_o.minute_value = empty ? '0 : minute_value;
  assign rsp_o.second_value = empty ? '0 : second_value;

endmodule

`default_nettype wire
